### hdl/cps_pkg.sv
package cps_pkg;

   // default coordinate width
   localparam int COORD_BITS_DEF = 12;

   // configuration register file
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 48;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_COEF_X_SQUARE = 3'd0,
      CSR_COEF_X_LINEAR = 3'd1,
      CSR_COEF_Y_SQUARE = 3'd2,
      CSR_COEF_Y_LINEAR = 3'd3,
      CSR_LIGHT_VECTOR  = 3'd4,
      CSR_AMBIENT_LEVEL = 3'd5,
      CSR_TILE_COLOR    = 3'd6
   } csr_index_type;

   // fixed-point widths
   localparam int COEF_BITS  = 32;
   localparam int LIGHT_BITS = 16;
   localparam int ONE_BITS   = 17;              // Q16.16 one, shifted down
   localparam int NORM_BITS  = 30;              // normalized magnitude width
   localparam int SQ_BITS    = 62;              // sum of squares
   localparam int ROOT_BITS  = 31;              // floor sqrt of sum of squares
   localparam int NUM_BITS   = 49;              // signed dot product
   localparam int DIV_BITS   = NUM_BITS + 1;    // twice the magnitude
   localparam int QUO_BITS   = 16;
   localparam int COS_BITS   = 15;
   localparam int CHAN_BITS  = 8;
   localparam int PROD_BITS  = CHAN_BITS + COS_BITS;

endpackage

### hdl/cushion_pixel_shader.sv
// channel   ports                              direction
// request   req_valid req_stall req_pixel_x/y  in (stall out)
// response  rsp_valid rsp_stall rsp_*_out      out (stall in)
// csr       csr_wr_en csr_index csr_wdata      in, write only
//
// one pixel per clock while the response is not stalled
// pipeline stages: 6 front, 31 square root, 17 divide, 2 shading
// the bit-serial square root and the restoring divide set the depth
// reset clears only the valid bits and the configuration registers
// a stalled response freezes the whole pipeline; nothing is dropped
module cushion_pixel_shader #(
   parameter int COORD_BITS = cps_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [COORD_BITS-1:0]              req_pixel_x,
   input  logic [COORD_BITS-1:0]              req_pixel_y,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [cps_pkg::CHAN_BITS-1:0]      rsp_red_out,
   output logic [cps_pkg::CHAN_BITS-1:0]      rsp_green_out,
   output logic [cps_pkg::CHAN_BITS-1:0]      rsp_blue_out,
   input  logic                               csr_wr_en,
   input  logic [cps_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [cps_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import cps_pkg::*;

   // configuration registers
   logic signed [COEF_BITS-1:0] cxs_ff, cxl_ff, cys_ff, cyl_ff;
   logic [3*LIGHT_BITS-1:0]     light_ff;
   logic [CHAN_BITS-1:0]        amb_ff;
   logic [3*CHAN_BITS-1:0]      color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cxs_ff   <= '0;
         cxl_ff   <= '0;
         cys_ff   <= '0;
         cyl_ff   <= '0;
         light_ff <= '0;
         amb_ff   <= '0;
         color_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_COEF_X_SQUARE: cxs_ff   <= csr_wdata[COEF_BITS-1:0];
            CSR_COEF_X_LINEAR: cxl_ff   <= csr_wdata[COEF_BITS-1:0];
            CSR_COEF_Y_SQUARE: cys_ff   <= csr_wdata[COEF_BITS-1:0];
            CSR_COEF_Y_LINEAR: cyl_ff   <= csr_wdata[COEF_BITS-1:0];
            CSR_LIGHT_VECTOR:  light_ff <= csr_wdata[3*LIGHT_BITS-1:0];
            CSR_AMBIENT_LEVEL: amb_ff   <= csr_wdata[CHAN_BITS-1:0];
            CSR_TILE_COLOR:    color_ff <= csr_wdata[3*CHAN_BITS-1:0];
            default: ;  // unused index, write dropped
         endcase
      end
   end

   // whole pipeline moves unless the output holds a stalled response
   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   logic                       f_valid, s_valid, d_valid;
   logic [SQ_BITS-1:0]         f_sum;
   logic signed [NUM_BITS-1:0] f_num, s_num;
   logic [ROOT_BITS-1:0]       s_root;
   logic [QUO_BITS-1:0]        d_quo;
   logic                       d_ovf, d_pos;

   // normal, normalization, dot product and sum of squares
   cps_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (req_valid),
      .pixel_x       (req_pixel_x),
      .pixel_y       (req_pixel_y),
      .coef_x_square (cxs_ff),
      .coef_x_linear (cxl_ff),
      .coef_y_square (cys_ff),
      .coef_y_linear (cyl_ff),
      .light_x       (light_ff[LIGHT_BITS-1:0]),
      .light_y       (light_ff[2*LIGHT_BITS-1:LIGHT_BITS]),
      .light_z       (light_ff[3*LIGHT_BITS-1:2*LIGHT_BITS]),
      .out_valid     (f_valid),
      .sum_sq        (f_sum),
      .num           (f_num)
   );

   // length of the normal
   cps_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .sum_sq    (f_sum),
      .in_num    (f_num),
      .out_valid (s_valid),
      .root      (s_root),
      .out_num   (s_num)
   );

   // cosine as twice the dot product over the length
   cps_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .den       (s_root),
      .num       (s_num),
      .out_valid (d_valid),
      .quo       (d_quo),
      .ovf       (d_ovf),
      .pos       (d_pos)
   );

   // per-channel shading into the response register
   cps_shade u_shade (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (d_valid),
      .quo           (d_quo),
      .ovf           (d_ovf),
      .pos           (d_pos),
      .tile_color    (color_ff),
      .ambient_level (amb_ff),
      .out_valid     (rsp_valid),
      .red_out       (rsp_red_out),
      .green_out     (rsp_green_out),
      .blue_out      (rsp_blue_out)
   );

endmodule

### hdl/cps_front.sv
module cps_front #(
   parameter int COORD_BITS = cps_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic [COORD_BITS-1:0]                 pixel_x,
   input  logic [COORD_BITS-1:0]                 pixel_y,
   input  logic signed [cps_pkg::COEF_BITS-1:0]  coef_x_square,
   input  logic signed [cps_pkg::COEF_BITS-1:0]  coef_x_linear,
   input  logic signed [cps_pkg::COEF_BITS-1:0]  coef_y_square,
   input  logic signed [cps_pkg::COEF_BITS-1:0]  coef_y_linear,
   input  logic signed [cps_pkg::LIGHT_BITS-1:0] light_x,
   input  logic signed [cps_pkg::LIGHT_BITS-1:0] light_y,
   input  logic signed [cps_pkg::LIGHT_BITS-1:0] light_z,
   output logic                                  out_valid,
   output logic [cps_pkg::SQ_BITS-1:0]           sum_sq,
   output logic signed [cps_pkg::NUM_BITS-1:0]   num
);
   import cps_pkg::*;

   localparam int MW = COEF_BITS + COORD_BITS + 1;
   localparam int NW = MW + 1;
   localparam logic [NW-1:0] LIMIT = NW'(1) << NORM_BITS;
   localparam logic [NW-1:0] ONE_W = NW'(1) << 16;

   logic [5:0] v_ff;

   // stage 1: coefficient times coordinate
   logic signed [MW-1:0] mx_ff, my_ff;
   // stage 2: normal components
   logic signed [NW-1:0] nx_ff, ny_ff;
   // stage 3/4: normalizing shift
   logic [NW-1:0] ax3_ff, ay3_ff, m3_ff, ax3_in, ay3_in, m3_in;
   logic [ONE_BITS-1:0] one3_ff, one3_in;
   logic sx3_ff, sy3_ff;
   logic [NORM_BITS-1:0] ax4_ff, ay4_ff, ax4_in, ay4_in;
   logic [ONE_BITS-1:0] one4_ff, one4_in;
   logic sx4_ff, sy4_ff;
   // stage 5: products
   logic [2*NORM_BITS-1:0] sqx_ff, sqy_ff;
   logic [2*ONE_BITS-1:0] sqo_ff;
   logic signed [NORM_BITS+LIGHT_BITS:0] px_ff, py_ff;
   logic signed [ONE_BITS+LIGHT_BITS:0] pz_ff;
   // stage 6
   logic [SQ_BITS-1:0] sum_ff;
   logic signed [NUM_BITS-1:0] num_ff;

   logic signed [COORD_BITS:0] pxs, pys;
   logic signed [NORM_BITS:0] sxs, sys;
   logic signed [ONE_BITS:0] ones;

   assign pxs = {1'b0, pixel_x};
   assign pys = {1'b0, pixel_y};

   // coarse shifts by 16, 8, 4
   always_comb begin
      logic [NW-1:0] ax, ay, m;
      logic [ONE_BITS-1:0] one;
      ax  = nx_ff[NW-1] ? NW'(-nx_ff) : NW'(nx_ff);
      ay  = ny_ff[NW-1] ? NW'(-ny_ff) : NW'(ny_ff);
      m   = ONE_W;
      if (ax > m) m = ax;
      if (ay > m) m = ay;
      one = ONE_BITS'(ONE_W);
      for (int i = 0; i < 3; i++) begin
         if ((m >> (16 >> i)) >= LIMIT) begin
            m   = m >> (16 >> i);
            ax  = ax >> (16 >> i);
            ay  = ay >> (16 >> i);
            one = one >> (16 >> i);
         end
      end
      ax3_in  = ax;
      ay3_in  = ay;
      m3_in   = m;
      one3_in = one;
   end

   // fine shifts by 2, 1, then the final step below the limit
   always_comb begin
      logic [NW-1:0] ax, ay, m;
      logic [ONE_BITS-1:0] one;
      ax  = ax3_ff;
      ay  = ay3_ff;
      m   = m3_ff;
      one = one3_ff;
      for (int i = 0; i < 2; i++) begin
         if ((m >> (2 >> i)) >= LIMIT) begin
            m   = m >> (2 >> i);
            ax  = ax >> (2 >> i);
            ay  = ay >> (2 >> i);
            one = one >> (2 >> i);
         end
      end
      if (m >= LIMIT) begin
         ax  = ax >> 1;
         ay  = ay >> 1;
         one = one >> 1;
      end
      ax4_in  = ax[NORM_BITS-1:0];
      ay4_in  = ay[NORM_BITS-1:0];
      one4_in = one;
   end

   assign sxs  = sx4_ff ? -$signed({1'b0, ax4_ff}) : $signed({1'b0, ax4_ff});
   assign sys  = sy4_ff ? -$signed({1'b0, ay4_ff}) : $signed({1'b0, ay4_ff});
   assign ones = $signed({1'b0, one4_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
      if (en) begin
         mx_ff   <= coef_x_square * pxs;
         my_ff   <= coef_y_square * pys;
         nx_ff   <= (NW'(mx_ff) <<< 1) + NW'(coef_x_linear);
         ny_ff   <= (NW'(my_ff) <<< 1) + NW'(coef_y_linear);
         ax3_ff  <= ax3_in;
         ay3_ff  <= ay3_in;
         m3_ff   <= m3_in;
         one3_ff <= one3_in;
         sx3_ff  <= nx_ff[NW-1];
         sy3_ff  <= ny_ff[NW-1];
         ax4_ff  <= ax4_in;
         ay4_ff  <= ay4_in;
         one4_ff <= one4_in;
         sx4_ff  <= sx3_ff;
         sy4_ff  <= sy3_ff;
         sqx_ff  <= ax4_ff * ax4_ff;
         sqy_ff  <= ay4_ff * ay4_ff;
         sqo_ff  <= one4_ff * one4_ff;
         px_ff   <= sxs * light_x;
         py_ff   <= sys * light_y;
         pz_ff   <= ones * light_z;
         sum_ff  <= SQ_BITS'(sqx_ff) + SQ_BITS'(sqy_ff) + SQ_BITS'(sqo_ff);
         num_ff  <= NUM_BITS'(px_ff) + NUM_BITS'(py_ff) + NUM_BITS'(pz_ff);
      end
   end

   assign out_valid = v_ff[5];
   assign sum_sq    = sum_ff;
   assign num       = num_ff;

endmodule

### hdl/cps_isqrt.sv
module cps_isqrt (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [cps_pkg::SQ_BITS-1:0]         sum_sq,
   input  logic signed [cps_pkg::NUM_BITS-1:0] in_num,
   output logic                                out_valid,
   output logic [cps_pkg::ROOT_BITS-1:0]       root,
   output logic signed [cps_pkg::NUM_BITS-1:0] out_num
);
   import cps_pkg::*;

   logic                        v_ff    [ROOT_BITS];
   logic [SQ_BITS-1:0]          rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0]        root_ff [ROOT_BITS];
   logic signed [NUM_BITS-1:0]  num_ff  [ROOT_BITS];

   // one root bit per stage, most significant first
   for (genvar i = 0; i < ROOT_BITS; i++) begin : g_step
      localparam int B = ROOT_BITS - 1 - i;
      logic                       v_i;
      logic [SQ_BITS-1:0]         rem_i;
      logic [ROOT_BITS-1:0]       root_i;
      logic signed [NUM_BITS-1:0] num_i;
      logic [SQ_BITS:0]           trial;
      logic                       take;

      if (i == 0) begin : g_first
         assign v_i    = in_valid;
         assign rem_i  = sum_sq;
         assign root_i = '0;
         assign num_i  = in_num;
      end else begin : g_next
         assign v_i    = v_ff[i-1];
         assign rem_i  = rem_ff[i-1];
         assign root_i = root_ff[i-1];
         assign num_i  = num_ff[i-1];
      end

      assign trial = ((SQ_BITS+1)'(root_i) << (B + 1)) + ((SQ_BITS+1)'(1) << (2 * B));
      assign take  = {1'b0, rem_i} >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_i;
         end
         if (en) begin
            rem_ff[i]  <= take ? rem_i - trial[SQ_BITS-1:0] : rem_i;
            root_ff[i] <= take ? (root_i | (ROOT_BITS'(1) << B)) : root_i;
            num_ff[i]  <= num_i;
         end
      end
   end

   assign out_valid = v_ff[ROOT_BITS-1];
   assign root      = root_ff[ROOT_BITS-1];
   assign out_num   = num_ff[ROOT_BITS-1];

endmodule

### hdl/cps_div.sv
module cps_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [cps_pkg::ROOT_BITS-1:0]       den,
   input  logic signed [cps_pkg::NUM_BITS-1:0] num,
   output logic                                out_valid,
   output logic [cps_pkg::QUO_BITS-1:0]        quo,
   output logic                                ovf,
   output logic                                pos
);
   import cps_pkg::*;

   localparam int ST = QUO_BITS + 1;

   logic                  v_ff   [ST];
   logic [DIV_BITS-1:0]   rem_ff [ST];
   logic [ROOT_BITS-1:0]  den_ff [ST];
   logic [QUO_BITS-1:0]   quo_ff [ST];
   logic                  ovf_ff [ST];
   logic                  pos_ff [ST];

   logic [DIV_BITS-1:0] dvd;
   assign dvd = num[NUM_BITS-1] ? DIV_BITS'(-num) << 1 : DIV_BITS'(num) << 1;

   // entry: twice the magnitude, quotient overflow check, positive sign flag
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         rem_ff[0] <= dvd;
         den_ff[0] <= den;
         quo_ff[0] <= '0;
         ovf_ff[0] <= dvd >= (DIV_BITS'(den) << QUO_BITS);
         pos_ff[0] <= !num[NUM_BITS-1] && (num != '0);
      end
   end

   // restoring steps, one quotient bit each
   for (genvar i = 1; i < ST; i++) begin : g_step
      localparam int B = QUO_BITS - i;
      logic [DIV_BITS-1:0] sub;
      logic                take;
      assign sub  = DIV_BITS'(den_ff[i-1]) << B;
      assign take = rem_ff[i-1] >= sub;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_ff[i-1];
         end
         if (en) begin
            rem_ff[i] <= take ? rem_ff[i-1] - sub : rem_ff[i-1];
            quo_ff[i] <= take ? (quo_ff[i-1] | (QUO_BITS'(1) << B)) : quo_ff[i-1];
            den_ff[i] <= den_ff[i-1];
            ovf_ff[i] <= ovf_ff[i-1];
            pos_ff[i] <= pos_ff[i-1];
         end
      end
   end

   assign out_valid = v_ff[ST-1];
   assign quo       = quo_ff[ST-1];
   assign ovf       = ovf_ff[ST-1];
   assign pos       = pos_ff[ST-1];

endmodule

### hdl/cps_shade.sv
module cps_shade (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [cps_pkg::QUO_BITS-1:0]         quo,
   input  logic                                 ovf,
   input  logic                                 pos,
   input  logic [3*cps_pkg::CHAN_BITS-1:0]      tile_color,
   input  logic [cps_pkg::CHAN_BITS-1:0]        ambient_level,
   output logic                                 out_valid,
   output logic [cps_pkg::CHAN_BITS-1:0]        red_out,
   output logic [cps_pkg::CHAN_BITS-1:0]        green_out,
   output logic [cps_pkg::CHAN_BITS-1:0]        blue_out
);
   import cps_pkg::*;

   logic [COS_BITS-1:0]  cosq;
   logic                 va_ff, vb_ff;
   logic [PROD_BITS-1:0] prod_ff [3];
   logic [CHAN_BITS-1:0] chan_ff [3];

   // positive cosine only, saturated below one
   always_comb begin
      if (!pos) begin
         cosq = '0;
      end else if (ovf || quo[QUO_BITS-1]) begin
         cosq = '1;
      end else begin
         cosq = quo[COS_BITS-1:0];
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_chan
      logic [CHAN_BITS-1:0] base, span;
      logic [PROD_BITS:0]   rnd;
      logic [CHAN_BITS+1:0] sum;
      assign base = tile_color[(2-c)*CHAN_BITS +: CHAN_BITS];
      assign span = (base > ambient_level) ? base - ambient_level : '0;
      assign rnd  = (PROD_BITS+1)'(prod_ff[c]) + ((PROD_BITS+1)'(1) << (COS_BITS - 1));
      assign sum  = (CHAN_BITS+2)'(rnd[PROD_BITS:COS_BITS]) + (CHAN_BITS+2)'(ambient_level);

      always_ff @(posedge clock) begin
         if (en) begin
            prod_ff[c] <= span * cosq;
            chan_ff[c] <= (sum > (CHAN_BITS+2)'({CHAN_BITS{1'b1}})) ? '1
                                                                     : sum[CHAN_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   assign out_valid = vb_ff;
   assign red_out   = chan_ff[0];
   assign green_out = chan_ff[1];
   assign blue_out  = chan_ff[2];

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import cps_pkg::*;

   // cycle budget: ~1400 pixels under worst-case stalls, plus per-phase drains
   // of the full pipeline, taken many times over
   localparam int CYCLE_LIMIT = 400000;
   localparam int PIPE_DEPTH  = 56;
   localparam int NUM_PHASES  = 13;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } shade_rgb_type;

   // shading settings mirrored from the register writes
   typedef struct {
      logic [31:0] x_square;
      logic [31:0] x_linear;
      logic [31:0] y_square;
      logic [31:0] y_linear;
      logic [47:0] light;
      logic [7:0]  ambient;
      logic [23:0] color;
   } shade_cfg_type;

   // floor integer square root, bit-serial as in hardware
   function automatic logic [63:0] floor_root(logic [63:0] s);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // one channel: scale the part above ambient by the cosine, round up at half
   function automatic logic [7:0] shade_channel(logic [7:0] base, logic [7:0] amb,
                                                longint cosq);
      longint m;
      longint v;
      m = (base > amb) ? longint'(base) - longint'(amb) : 0;
      v = 0;
      if (cosq > 0) v = (m * cosq + 16384) >>> 15;
      v = v + amb;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   function automatic shade_rgb_type shade_pixel(shade_cfg_type c, logic [11:0] px,
                                                 logic [11:0] py);
      longint nx, ny, lx, ly, lz, sx, sy, num, cosq;
      logic [63:0] ax, ay, m, one, den, q;
      int k;
      shade_rgb_type o;
      nx = 2 * longint'($signed(c.x_square)) * longint'({1'b0, px})
           + longint'($signed(c.x_linear));
      ny = 2 * longint'($signed(c.y_square)) * longint'({1'b0, py})
           + longint'($signed(c.y_linear));
      lx = longint'($signed(c.light[15:0]));
      ly = longint'($signed(c.light[31:16]));
      lz = longint'($signed(c.light[47:32]));
      ax = (nx < 0) ? -nx : nx;
      ay = (ny < 0) ? -ny : ny;
      m = 64'd1 << 16;
      if (ax > m) m = ax;
      if (ay > m) m = ay;
      k = 0;
      while (k < 63 && (m >> k) >= (64'd1 << 30)) k++;
      ax = ax >> k;
      ay = ay >> k;
      one = (64'd1 << 16) >> k;
      den = floor_root(ax * ax + ay * ay + one * one);
      if (den == 0) den = 1;
      sx = (nx < 0) ? -longint'(ax) : longint'(ax);
      sy = (ny < 0) ? -longint'(ay) : longint'(ay);
      num = sx * lx + sy * ly + longint'(one) * lz;
      q = (((num < 0) ? -num : num) * 2) / den;
      if (num < 0) cosq = (q > 32768) ? -32768 : -longint'(q);
      else cosq = (q > 32767) ? 32767 : longint'(q);
      o.red   = shade_channel(c.color[23:16], c.ambient, cosq);
      o.green = shade_channel(c.color[15:8], c.ambient, cosq);
      o.blue  = shade_channel(c.color[7:0], c.ambient, cosq);
      return o;
   endfunction

   class shade_board;
      shade_cfg_type cfg;
      shade_rgb_type pending[$];
      int errors;

      function void note_pixel(logic [11:0] px, logic [11:0] py);
         pending.push_back(shade_pixel(cfg, px, py));
      endfunction

      function void check_pixel(shade_rgb_type got);
         shade_rgb_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %h", got);
            return;
         end
         want = pending.pop_front();
         if (got.red !== want.red || got.green !== want.green
             || got.blue !== want.blue) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected r %0d g %0d b %0d, got r %0d g %0d b %0d",
                        want.red, want.green, want.blue, got.red, got.green, got.blue);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [11:0] req_pixel_x;
   logic [11:0] req_pixel_y;
   logic rsp_valid;
   logic rsp_stall;
   logic [7:0] rsp_red_out;
   logic [7:0] rsp_green_out;
   logic [7:0] rsp_blue_out;
   logic csr_wr_en;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   shade_board board;
   int cycle_count;
   int stall_mode;

   cushion_pixel_shader DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pixel_x(req_pixel_x), .req_pixel_y(req_pixel_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_red_out(rsp_red_out), .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // cycle watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // response side: check each accepted response, sampled at the edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_pixel({rsp_red_out, rsp_green_out, rsp_blue_out});
   end

   // receiver stall pattern; mode changes per phase, mode 0 never stalls
   always @(posedge clock) begin
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= (cycle_count % 7 < 3);
      endcase
   end

   // write enable stays high across a run of writes; the caller drops it
   task automatic csr_write(csr_index_type idx, logic [47:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_COEF_X_SQUARE: board.cfg.x_square = val[31:0];
         CSR_COEF_X_LINEAR: board.cfg.x_linear = val[31:0];
         CSR_COEF_Y_SQUARE: board.cfg.y_square = val[31:0];
         CSR_COEF_Y_LINEAR: board.cfg.y_linear = val[31:0];
         CSR_LIGHT_VECTOR:  board.cfg.light = val;
         CSR_AMBIENT_LEVEL: board.cfg.ambient = val[7:0];
         default:           board.cfg.color = val[23:0];
      endcase
   endtask

   // hold one request until it is accepted; valid stays high across a burst
   task automatic send_pixel(logic [11:0] px, logic [11:0] py);
      req_valid <= 1'b1;
      req_pixel_x <= px;
      req_pixel_y <= py;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_pixel(px, py);
   endtask

   task automatic idle_cycles(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // let the pipeline drain fully before touching the registers
   task automatic drain_all();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 8) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coef(int kind);
      case (kind)
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 2) == 0 ? 32'd0 : $urandom;
         default: return 32'($signed($urandom_range(0, 262143)) - 131072);
      endcase
   endfunction

   task automatic random_config(int phase);
      logic [15:0] lx, ly, lz;
      if (phase == 1) begin
         // extremes everywhere
         csr_write(CSR_COEF_X_SQUARE, 48'h8000_0000);
         csr_write(CSR_COEF_X_LINEAR, 48'h7fff_ffff);
         csr_write(CSR_COEF_Y_SQUARE, 48'h7fff_ffff);
         csr_write(CSR_COEF_Y_LINEAR, 48'h8000_0000);
         csr_write(CSR_LIGHT_VECTOR, 48'h8000_7fff_8000);
         csr_write(CSR_AMBIENT_LEVEL, 48'd255);
         csr_write(CSR_TILE_COLOR, 48'hffffff);
      end else if (phase == 2) begin
         // unnormalized light on a flat tile: cosine saturates
         csr_write(CSR_COEF_X_SQUARE, 48'd0);
         csr_write(CSR_COEF_X_LINEAR, 48'd0);
         csr_write(CSR_COEF_Y_SQUARE, 48'd0);
         csr_write(CSR_COEF_Y_LINEAR, 48'd0);
         csr_write(CSR_LIGHT_VECTOR, 48'h7fff_7fff_7fff);
         csr_write(CSR_AMBIENT_LEVEL, 48'd0);
         csr_write(CSR_TILE_COLOR, 48'hff80_01);
      end else begin
         csr_write(CSR_COEF_X_SQUARE, {16'h0, rand_coef($urandom_range(0, 5))});
         csr_write(CSR_COEF_X_LINEAR, {16'h0, rand_coef($urandom_range(0, 5))});
         csr_write(CSR_COEF_Y_SQUARE, {16'h0, rand_coef($urandom_range(0, 5))});
         csr_write(CSR_COEF_Y_LINEAR, {16'h0, rand_coef($urandom_range(0, 5))});
         // mostly near-unit light, sometimes raw bits
         lx = 16'($signed($urandom_range(0, 16384)) - 8192);
         ly = 16'($signed($urandom_range(0, 16384)) - 8192);
         lz = 16'($urandom_range(4096, 16384));
         if ($urandom_range(0, 3) == 0) {lz, ly, lx} = 48'({$urandom, $urandom});
         csr_write(CSR_LIGHT_VECTOR, {lz, ly, lx});
         // ambient sometimes above base
         csr_write(CSR_AMBIENT_LEVEL, 48'($urandom_range(0, 255)));
         csr_write(CSR_TILE_COLOR, 48'($urandom & 24'hffffff));
      end
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int burst;
      board = new();
      board.cfg = '{default: '0};
      cycle_count = 0;
      stall_mode = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_pixel_x <= '0;
      req_pixel_y <= '0;
      rsp_stall <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, coordinate corners
      send_pixel(12'd0, 12'd0);
      send_pixel(12'hfff, 12'hfff);
      drain_all();
      for (int ph = 1; ph <= NUM_PHASES; ph++) begin
         random_config(ph);
         stall_mode = ph % 4;
         if (ph <= 2) begin
            // corners and single-bit coordinates under the extreme settings
            send_pixel(12'd0, 12'd0);
            send_pixel(12'hfff, 12'd0);
            send_pixel(12'd0, 12'hfff);
            send_pixel(12'hfff, 12'hfff);
            for (int b = 0; b < 12; b += 3) send_pixel(12'd1 << b, 12'd1 << (11 - b));
         end else begin
            for (int n = 0; n < 120; ) begin
               burst = $urandom_range(1, 24);
               for (int j = 0; j < burst && n < 120; j++, n++)
                  send_pixel(12'($urandom), 12'($urandom));
               if ($urandom_range(0, 9) == 0) begin
                  // hold off until the pipeline has answered everything
                  req_valid <= 1'b0;
                  while (board.pending.size() != 0) @(posedge clock);
               end else if ($urandom_range(0, 2) != 0) begin
                  idle_cycles($urandom_range(1, 8));
               end
            end
         end
         drain_all();
      end

      if (board.errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end
endmodule
